FILE: sv/iso2sjs_pkg.sv
// Types and codes for the ISO-2022-JP to Shift_JIS stream converter.
// No dependencies; every module of the block imports this package.
`default_nettype none

package iso2sjs_pkg;

  // Input beat: one source byte, or the end-of-text marker.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_beat_t;

  // Output beat: one Shift_JIS byte, or the closing terminator.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_text;
  } out_beat_t;

  // Escape or pair step that is waiting for its next byte.
  typedef enum logic [7:0] {
    PendIdle   = 8'b0000_0001,
    PendEsc    = 8'b0000_0010,
    PendDollar = 8'b0000_0100,
    PendParen  = 8'b0000_1000,
    PendStar   = 8'b0001_0000,
    PendSs     = 8'b0010_0000,
    PendKanji2 = 8'b0100_0000,
    PendEuc2   = 8'b1000_0000
  } pend_e;

  localparam logic [7:0] ChEsc    = 8'h1B;
  localparam logic [7:0] ChSo     = 8'h0E;
  localparam logic [7:0] ChSi     = 8'h0F;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChParen  = 8'h28;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChB      = 8'h42;
  localparam logic [7:0] ChH      = 8'h48;
  localparam logic [7:0] ChI      = 8'h49;
  localparam logic [7:0] ChJ      = 8'h4A;
  localparam logic [7:0] ChK      = 8'h4B;
  localparam logic [7:0] ChN      = 8'h4E;
  localparam logic [7:0] JisLo    = 8'h21;
  localparam logic [7:0] JisHi    = 8'h7E;
  localparam logic [7:0] EucLo    = 8'hA1;
  localparam logic [7:0] EucHi    = 8'hFE;
  localparam logic [7:0] HighBit  = 8'h80;
  localparam logic [7:0] EucMask  = 8'h7F;

endpackage

`default_nettype wire

FILE: sv/iso2022jp_to_shift_jis_stream.sv
// Top level of the ISO-2022-JP to Shift_JIS stream converter.
// Depends on iso2sjs_pkg for beat types, pending-step codes and byte codes.
`default_nettype none

// One source byte per input beat. A byte lands in an input register; when the
// three-entry result buffer is free (empty, or its last entry leaves this
// cycle) the conversion step runs and writes 0 to 3 result bytes into it.
// The buffer drains one beat per cycle while out_ready_i is high, so a byte
// that yields k results holds the output port until all k have left: sustained
// throughput is one input byte per cycle while each byte yields at most one
// result and the output does not stall.
// Lead bytes, escape prefixes and mode changes yield nothing. The input
// register takes a new beat while results still wait on a stalled output.
// end_of_text flushes a pending ESC $ or ESC (, emits a zero byte flagged
// last_of_text, and returns all modes to their reset values.
module iso2022jp_to_shift_jis_stream
  import iso2sjs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  // Input register
  in_beat_t   in_q;
  logic       in_valid_q, in_valid_d;

  // Converter state
  pend_e      pend_q, pend_d;
  logic       kanji_q, kanji_d;
  logic       half_q, half_d;
  logic       so_q, so_d;
  logic [7:0] held_q, held_d;

  // Result buffer, entry 0 drives the output
  out_beat_t  buf0_q, buf1_q, buf2_q;
  out_beat_t  buf0_d, buf1_d, buf2_d;
  logic [1:0] cnt_q, cnt_d;

  // Step results
  out_beat_t  r0, r1, r2;
  logic [1:0] n_res;

  logic pop, consume, buf_free;

  assign pop         = out_valid_o && out_ready_i;
  assign buf_free    = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign consume     = in_valid_q && buf_free;
  assign in_ready_o  = !in_valid_q || consume;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf0_q;

  function automatic logic [15:0] jis_to_sjs(input logic [7:0] hi, input logic [7:0] lo);
    logic [8:0] hs;
    logic [7:0] lo_o;
    if (hi[0]) begin
      lo_o = lo + ((lo < 8'h60) ? 8'h1F : 8'h20);
    end else begin
      lo_o = lo + 8'h7E;
    end
    if (hi < 8'h5F) begin
      hs = {1'b0, hi} + 9'h0E1;
    end else begin
      hs = {1'b0, hi} + 9'h161;
    end
    return {hs[8:1], lo_o};
  endfunction

  function automatic out_beat_t beat(input logic [7:0] b);
    out_beat_t o;
    o.out_byte     = b;
    o.last_of_text = 1'b0;
    return o;
  endfunction

  logic [7:0]  c;
  logic [15:0] pair_jis, pair_euc;
  logic        run_idle, go;

  assign c        = in_q.in_byte;
  assign pair_jis = jis_to_sjs(held_q, c);
  assign pair_euc = jis_to_sjs(held_q & EucMask, c & EucMask);

  always_comb begin
    pend_d   = pend_q;
    kanji_d  = kanji_q;
    half_d   = half_q;
    so_d     = so_q;
    held_d   = held_q;
    r0       = beat(8'h00);
    r1       = beat(8'h00);
    r2       = beat(8'h00);
    n_res    = 2'd0;
    run_idle = 1'b0;
    go       = 1'b0;

    if (in_q.end_of_text) begin
      // flush ESC $ or ESC ( then close the text
      pend_d  = PendIdle;
      kanji_d = 1'b0;
      half_d  = 1'b0;
      so_d    = 1'b0;
      held_d  = 8'h00;
      if (pend_q == PendDollar || pend_q == PendParen) begin
        r0       = beat(ChEsc);
        r1       = beat((pend_q == PendDollar) ? ChDollar : ChParen);
        r2.out_byte     = 8'h00;
        r2.last_of_text = 1'b1;
        n_res    = 2'd3;
      end else begin
        r0.out_byte     = 8'h00;
        r0.last_of_text = 1'b1;
        n_res    = 2'd1;
      end
    end else begin
      unique case (pend_q)
        PendEsc: begin
          pend_d = PendIdle;
          priority if (c == ChDollar) begin
            pend_d = PendDollar;
          end else if (c == ChParen) begin
            pend_d = PendParen;
          end else if (c == ChStar) begin
            pend_d = PendStar;
          end else if (half_q && c == ChN) begin
            pend_d = PendSs;
          end else if (c == ChK) begin
            kanji_d = 1'b1;
          end else if (c == ChH) begin
            kanji_d = 1'b0;
          end else begin
            r0    = beat(ChEsc);
            r1    = beat(c);
            n_res = 2'd2;
          end
        end
        PendDollar: begin
          pend_d = PendIdle;
          if (c == ChAt || c == ChB) begin
            kanji_d = 1'b1;
          end else begin
            r0    = beat(ChEsc);
            r1    = beat(ChDollar);
            r2    = beat(c);
            n_res = 2'd3;
          end
        end
        PendParen: begin
          pend_d  = PendIdle;
          kanji_d = 1'b0;
          if (!(c == ChH || c == ChJ || c == ChB)) begin
            r0    = beat(ChEsc);
            r1    = beat(ChParen);
            r2    = beat(c);
            n_res = 2'd3;
          end
        end
        PendStar: begin
          pend_d = PendIdle;
          if (c == ChB) begin
            half_d = 1'b0;
          end else if (c == ChI) begin
            half_d = 1'b1;
          end
        end
        PendSs: begin
          pend_d = PendIdle;
          r0     = beat(c ^ HighBit);
          n_res  = 2'd1;
        end
        PendKanji2: begin
          pend_d = PendIdle;
          held_d = 8'h00;
          n_res  = 2'd2;
          if (c >= JisLo && c <= JisHi) begin
            r0 = beat(pair_jis[15:8]);
            r1 = beat(pair_jis[7:0]);
          end else begin
            r0 = beat(held_q);
            r1 = beat(c);
          end
        end
        PendEuc2: begin
          pend_d = PendIdle;
          held_d = 8'h00;
          n_res  = 2'd2;
          if (c >= EucLo && c <= EucHi) begin
            r0 = beat(pair_euc[15:8]);
            r1 = beat(pair_euc[7:0]);
          end else begin
            r0 = beat(held_q);
            r1 = beat(c);
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      if (run_idle) begin
        pend_d = PendIdle;
        go     = 1'b1;
        if (so_q) begin
          priority if (c == ChSi) begin
            so_d = 1'b0;
            go   = 1'b0;
          end else if (c == ChCr || c == ChLf || c == ChEsc) begin
            so_d = 1'b0;
          end else begin
            r0    = beat(c ^ HighBit);
            n_res = 2'd1;
            go    = 1'b0;
          end
        end
        if (go) begin
          priority if (c == ChEsc) begin
            pend_d = PendEsc;
          end else if (kanji_q && (c == ChCr || c == ChLf)) begin
            kanji_d = 1'b0;
            r0      = beat(c);
            n_res   = 2'd1;
          end else if (kanji_q && c >= JisLo && c <= JisHi) begin
            held_d = c;
            pend_d = PendKanji2;
          end else if (c >= EucLo && c <= EucHi) begin
            held_d = c;
            pend_d = PendEuc2;
          end else if (c == ChSo) begin
            so_d = 1'b1;
          end else begin
            r0    = beat(c);
            n_res = 2'd1;
          end
        end
      end
    end
  end

  // Result buffer: load a fresh set on consume, else shift out on pop
  always_comb begin
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    buf2_d = buf2_q;
    cnt_d  = cnt_q;
    if (consume) begin
      buf0_d = r0;
      buf1_d = r1;
      buf2_d = r2;
      cnt_d  = n_res;
    end else if (pop) begin
      buf0_d = buf1_q;
      buf1_d = buf2_q;
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= 2'd0;
      pend_q     <= PendIdle;
      kanji_q    <= 1'b0;
      half_q     <= 1'b0;
      so_q       <= 1'b0;
      held_q     <= 8'h00;
    end else begin
      in_valid_q <= in_valid_d;
      cnt_q      <= cnt_d;
      if (consume) begin
        pend_q  <= pend_d;
        kanji_q <= kanji_d;
        half_q  <= half_d;
        so_q    <= so_d;
        held_q  <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
    buf2_q <= buf2_d;
  end

`ifndef SYNTH
  // The terminator is always the final entry of its set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_of_text) |-> (cnt_q == 2'd1))
    else $error("terminator not at the tail of the result buffer");

  // While the terminator waits, the converter already sits in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_of_text) |->
      (pend_q == PendIdle && !kanji_q && !half_q && !so_q && held_q == 8'h00))
    else $error("state not cleared after end of text");

  // A new step never overwrites results that are still owed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
    else $error("result buffer overwritten");

  // A stalled input register keeps its beat until the step runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !consume) |=> (in_valid_q && $stable(in_q)))
    else $error("held input beat lost");
`endif

endmodule

`default_nettype wire
